@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent this cycle implies consequent on the same edge.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent this cycle implies consequent on the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/kvs_pkg.sv @@
// ----------------------------------------------------------------------------
// kvs_pkg
// Shared types and constants for the keyframe vector sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package kvs_pkg;

  localparam int MAX_KEYS_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 7;
  localparam int FRAC_W       = 16;
  localparam int QUO_W        = FRAC_W + 1;        // frac spans 0 .. 1.0
  localparam int STEP_W       = $clog2(QUO_W + 1);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0]        t;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } key_entry_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/keyframe_vector_sampler.sv @@
// Load transfer: written to the key table at the accepting edge.
// Sample transfer: reads entry 0, done at or before the first key (or one
//   key in use); else scans segments (one table read per cycle), then on
//   a hit the divider (skipped on equal times) and shared multiplier.
// Next transfer is taken once the result sits in the output register.
// Sync reset clears control and sets key_count to 1; the table is not cleared.
// ----------------------------------------------------------------------------
// keyframe_vector_sampler
// Linear keyframe interpolation over a table of time / xyz vector entries.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module keyframe_vector_sampler #(
  parameter int MAX_KEYS = kvs_pkg::MAX_KEYS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // config
  input  wire                                 cfg_we,
  input  wire [kvs_pkg::CNT_W-1:0]            cfg_data,
  // input channel
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 opcode,
  input  wire [kvs_pkg::IDX_W-1:0]            key_index,
  input  wire [kvs_pkg::DATA_W-1:0]           key_time,
  input  wire signed [kvs_pkg::DATA_W-1:0]    key_x,
  input  wire signed [kvs_pkg::DATA_W-1:0]    key_y,
  input  wire signed [kvs_pkg::DATA_W-1:0]    key_z,
  input  wire [kvs_pkg::DATA_W-1:0]           query_time,
  // output channel
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic signed [kvs_pkg::DATA_W-1:0]   out_x,
  output logic signed [kvs_pkg::DATA_W-1:0]   out_y,
  output logic signed [kvs_pkg::DATA_W-1:0]   out_z
);

  localparam int AW     = $clog2(MAX_KEYS);
  localparam int WIDX_W = (AW > kvs_pkg::IDX_W) ? AW : kvs_pkg::IDX_W;
  localparam int DW     = kvs_pkg::DATA_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH0 = 3'd1;  // read entry 0
  localparam logic [2:0] S_CHECK0 = 3'd2;  // before-first-key test
  localparam logic [2:0] S_SCAN   = 3'd3;  // one segment per cycle
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // lerp phases per component
  localparam logic [1:0] PH_SUB = 2'd0;
  localparam logic [1:0] PH_MUL = 2'd1;
  localparam logic [1:0] PH_ACC = 2'd2;

  localparam logic [1:0] C_X = 2'd0;
  localparam logic [1:0] C_Y = 2'd1;
  localparam logic [1:0] C_Z = 2'd2;

  logic [2:0]                 state;
  logic [kvs_pkg::CNT_W-1:0]  key_count;
  logic [DW-1:0]              qtime;
  logic [AW-1:0]              last_idx;
  logic [AW-1:0]              idx;
  logic [kvs_pkg::QUO_W-1:0]  frac;
  logic [1:0]                 ph;
  logic [1:0]                 comp;

  kvs_pkg::key_entry_t        mem [MAX_KEYS];
  kvs_pkg::key_entry_t        rdata;
  kvs_pkg::key_entry_t        prev;      // segment start
  kvs_pkg::key_entry_t        bent;      // segment end
  logic [AW-1:0]              rd_addr;

  logic signed [DW-1:0]       res_x;
  logic signed [DW-1:0]       res_y;
  logic signed [DW-1:0]       res_z;

  logic signed [DW:0]         dreg;
  logic signed [49:0]         preg;
  logic signed [50:0]         prod_full;
  logic signed [49:0]         psh;
  logic signed [DW-1:0]       a_c;
  logic signed [DW-1:0]       b_c;
  logic signed [DW-1:0]       lerp_val;

  logic                       in_xfer;
  logic                       out_free;
  logic                       wr_en;
  logic [WIDX_W-1:0]          widx;
  logic [31:0]                kc_wide;
  logic [31:0]                n_eff;
  logic                       seg_hit;
  logic [DW-1:0]              seg_diff;
  logic [DW-1:0]              seg_den;

  kvs_pkg::div_ctl_t          div_ctl;
  kvs_pkg::div_sts_t          div_sts;
  logic [kvs_pkg::QUO_W-1:0]  div_quo;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // ---- config register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= kvs_pkg::CNT_W'(1);
    end else if (cfg_we) begin
      key_count <= cfg_data;
    end
  end

  // Keys in use: zero counts as one, clipped to table depth.
  assign kc_wide = 32'(key_count);
  always_comb begin
    if (kc_wide == 32'd0) begin
      n_eff = 32'd1;
    end else if (kc_wide > 32'(MAX_KEYS)) begin
      n_eff = 32'(MAX_KEYS);
    end else begin
      n_eff = kc_wide;
    end
  end

  // ---- key table: one write, one registered read ----
  assign widx  = WIDX_W'(key_index);
  assign wr_en = in_xfer && (opcode == kvs_pkg::OP_LOAD) &&
                 (32'(key_index) < 32'(MAX_KEYS));

  always_comb begin
    case (state)
      S_FETCH0: rd_addr = '0;
      S_CHECK0: rd_addr = AW'(1);
      S_SCAN:   rd_addr = idx + 1'b1;   // prefetch next end point
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[widx[AW-1:0]] <= '{t: key_time, x: key_x, y: key_y, z: key_z};
    end
    rdata <= mem[rd_addr];
  end

  // ---- segment test and divider launch ----
  assign seg_hit  = (prev.t <= qtime) && (qtime <= rdata.t);
  assign seg_diff = qtime - prev.t;
  assign seg_den  = rdata.t - prev.t;
  assign div_ctl.start = (state == S_SCAN) && seg_hit && (seg_den != '0);

  kvs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .diff (seg_diff),
    .den  (seg_den),
    .sts  (div_sts),
    .quo  (div_quo)
  );

  // ---- shared lerp datapath: sub, multiply, shift-add ----
  always_comb begin
    case (comp)
      C_X:     begin a_c = prev.x; b_c = bent.x; end
      C_Y:     begin a_c = prev.y; b_c = bent.y; end
      C_Z:     begin a_c = prev.z; b_c = bent.z; end
      default: begin a_c = prev.x; b_c = bent.x; end
    endcase
  end

  assign prod_full = dreg * $signed({1'b0, frac});
  assign psh       = preg >>> kvs_pkg::FRAC_W;    // floor toward -inf
  assign lerp_val  = a_c + psh[DW-1:0];

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ph    <= PH_SUB;
      comp  <= C_X;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer && (opcode == kvs_pkg::OP_SAMPLE)) begin
            state <= S_FETCH0;
          end
        end
        S_FETCH0: state <= S_CHECK0;
        S_CHECK0: begin
          if ((last_idx == '0) || (qtime <= rdata.t)) begin
            state <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (seg_hit) begin
            state <= (seg_den != '0) ? S_DIV : S_MUL;
            ph    <= PH_SUB;
            comp  <= C_X;
          end else if (idx == last_idx) begin
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_sts.done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          case (ph)
            PH_SUB: ph <= PH_MUL;
            PH_MUL: ph <= PH_ACC;
            default: begin
              ph <= PH_SUB;
              if (comp == C_Z) begin
                state <= S_DONE;
              end else begin
                comp <= comp + 1'b1;
              end
            end
          endcase
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      qtime    <= query_time;
      last_idx <= AW'(n_eff - 32'd1);
    end
    case (state)
      S_CHECK0: begin
        prev  <= rdata;
        idx   <= AW'(1);
        res_x <= rdata.x;
        res_y <= rdata.y;
        res_z <= rdata.z;
      end
      S_SCAN: begin
        if (seg_hit) begin
          bent <= rdata;
          frac <= '0;                   // equal times: stay at start value
        end else begin
          prev  <= rdata;
          idx   <= idx + 1'b1;
          res_x <= rdata.x;             // past the end: last key wins
          res_y <= rdata.y;
          res_z <= rdata.z;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          frac <= div_quo;
        end
      end
      S_MUL: begin
        case (ph)
          PH_SUB: dreg <= (DW+1)'(b_c) - (DW+1)'(a_c);
          PH_MUL: preg <= prod_full[49:0];
          default: begin
            case (comp)
              C_X:     res_x <= lerp_val;
              C_Y:     res_y <= lerp_val;
              default: res_z <= lerp_val;
            endcase
          end
        endcase
      end
      default: ;
    endcase
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_x <= res_x;
      out_y <= res_y;
      out_z <= res_z;
    end
  end

  // ---- checks ----
  `ASSERT_ALWAYS(a_div_no_restart, !(div_ctl.start && div_sts.busy), "divider restarted while busy")
  `ASSERT_IMPLY(a_scan_bound, state == S_SCAN, idx <= last_idx, "scan ran past last key")
  `ASSERT_IMPLY(a_frac_range, state == S_MUL, frac <= 17'h10000, "fraction above 1.0")
  `ASSERT_NEXT(a_done_loads, (state == S_DONE) && out_free, out_valid && (state == S_IDLE), "result not presented")

endmodule

`default_nettype wire

@@ rtl/core/kvs_div.sv @@
// ----------------------------------------------------------------------------
// kvs_div
// Restoring divider for the segment fraction: (diff << 16) / den, one
// quotient bit per cycle. Caller guarantees diff <= den and den != 0.
// ----------------------------------------------------------------------------
`default_nettype none

module kvs_div (
  input  wire                                clk,
  input  wire                                rst,
  input  wire kvs_pkg::div_ctl_t             ctl,
  input  wire [kvs_pkg::DATA_W-1:0]          diff,
  input  wire [kvs_pkg::DATA_W-1:0]          den,
  output kvs_pkg::div_sts_t                  sts,
  output logic [kvs_pkg::QUO_W-1:0]          quo
);

  logic [kvs_pkg::DATA_W-1:0] rem;
  logic [kvs_pkg::DATA_W-1:0] den_q;
  logic [kvs_pkg::QUO_W-1:0]  dbits;     // remaining dividend bits, MSB first
  logic [kvs_pkg::STEP_W-1:0] steps;
  logic                       busy;
  logic                       done;

  logic [kvs_pkg::DATA_W:0]   trial;
  logic [kvs_pkg::DATA_W:0]   trial_sub;
  logic                       ge;

  // Quotient < 2^17 so the top bits of the dividend start below den.
  assign trial     = {rem, dbits[kvs_pkg::QUO_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign ge        = (trial >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        steps <= kvs_pkg::STEP_W'(kvs_pkg::QUO_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == kvs_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem   <= {1'b0, diff[kvs_pkg::DATA_W-1:1]};
      dbits <= {diff[0], {kvs_pkg::FRAC_W{1'b0}}};
      den_q <= den;
      quo   <= '0;
    end else if (busy) begin
      rem   <= ge ? trial_sub[kvs_pkg::DATA_W-1:0] : trial[kvs_pkg::DATA_W-1:0];
      dbits <= {dbits[kvs_pkg::QUO_W-2:0], 1'b0};
      quo   <= {quo[kvs_pkg::QUO_W-2:0], ge};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

`default_nettype wire
